// File: design/ptv_pkg.sv
// Shared constants and status codes for the parent tree validator.
package ptv_pkg;

    localparam int MAX_NODES = 256;
    localparam int ID_WIDTH  = 32;
    localparam int ADDR_W    = $clog2(MAX_NODES);
    localparam int COUNT_W   = $clog2(MAX_NODES + 2);
    localparam int ST_W      = 4;

    localparam logic [ST_W-1:0] ST_OK        = 4'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 4'd1;
    localparam logic [ST_W-1:0] ST_ZERO      = 4'd2;
    localparam logic [ST_W-1:0] ST_DUP       = 4'd3;
    localparam logic [ST_W-1:0] ST_MISSING   = 4'd4;
    localparam logic [ST_W-1:0] ST_NOROOT    = 4'd5;
    localparam logic [ST_W-1:0] ST_MULTIROOT = 4'd6;
    localparam logic [ST_W-1:0] ST_CYCLE     = 4'd7;
    localparam logic [ST_W-1:0] ST_DEEP      = 4'd8;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 4'd9;

endpackage

// File: design/ptv_ram.sv
// Generic single-port RAM with registered read.
module ptv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: design/parent_tree_validator_top.sv
// Top level of the parent tree validator: node store, search sequencer, result register.
//
//  channel  | dir | tdata                          | tuser     | tlast
//  s_axis   | in  | node_id[31:0], par_id[63:32]   | has_node  | last
//  m_axis   | out | status[3:0], root_id[35:4]     | -         | -
//
// A node word passes through the write state; when the duplicate search runs, each
// stored node is first read and compared in turn over the shared memory address.
// The list end runs a missing-parent pass and a chain walk, each lookup being a
// linear search over the stored entries, so judging costs O(n^2) up to O(n^3) compares.
// Reset clears control and output registers only; the node memories need no clearing.
// A finished result waits in the output register; input is taken only while
// the sequencer is idle, and a new result stalls until the old one is taken.
module parent_tree_validator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // node_id[31:0], par_id[63:32]
    input  logic        s_axis_tuser,   // has_node
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // status[3:0], root_id[35:4], zero pad
);

    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_SRCH_RD, S_SRCH_CMP, S_JUDGE, S_MISS_RD, S_MISS_CHK,
        S_ROOTS, S_WALK_RD, S_WALK_INIT, S_WALK_STEP, S_EMIT
    } state_t;

    typedef enum logic [1:0] {M_DUP, M_MISS, M_WALK} mode_t;

    localparam int IW = ptv_pkg::ID_WIDTH;
    localparam int CW = ptv_pkg::COUNT_W;
    localparam int AW = ptv_pkg::ADDR_W;
    localparam int SW = ptv_pkg::ST_W;

    state_t          state_reg, state_next;
    mode_t           mode_reg, mode_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [1:0]      tally_reg, tally_next;
    logic [IW-1:0]   root_reg, root_next;
    logic [SW-1:0]   err_reg, err_next;
    logic [IW-1:0]   in_id_reg, in_id_next;
    logic [IW-1:0]   in_par_reg, in_par_next;
    logic            in_last_reg, in_last_next;
    logic [IW-1:0]   key_reg, key_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [IW-1:0]   self_reg, self_next;
    logic [IW-1:0]   cur_reg, cur_next;
    logic [CW-1:0]   steps_reg, steps_next;
    logic [SW-1:0]   res_reg, res_next;
    logic            out_valid_reg, out_valid_next;
    logic [SW-1:0]   out_status_reg, out_status_next;
    logic [IW-1:0]   out_root_reg, out_root_next;

    logic            mem_we;
    logic [CW-1:0]   mem_idx;
    logic [IW-1:0]   rd_id, rd_par;
    logic [IW-1:0]   s_id, s_par;
    logic            hit;
    logic [CW-1:0]   step_limit;

    assign s_id       = s_axis_tdata[31:0];
    assign s_par      = s_axis_tdata[63:32];
    assign hit        = (rd_id == key_reg);
    assign step_limit = count_reg + CW'(1);

    ptv_ram #(.WIDTH(IW), .DEPTH(ptv_pkg::MAX_NODES)) u_id_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_idx[AW-1:0]),
        .wdata (in_id_reg),
        .rdata (rd_id)
    );

    ptv_ram #(.WIDTH(IW), .DEPTH(ptv_pkg::MAX_NODES)) u_par_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_idx[AW-1:0]),
        .wdata (in_par_reg),
        .rdata (rd_par)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_root_reg, out_status_reg};

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        tally_next      = tally_reg;
        root_next       = root_reg;
        err_next        = err_reg;
        in_id_next      = in_id_reg;
        in_par_next     = in_par_reg;
        in_last_next    = in_last_reg;
        key_next        = key_reg;
        j_next          = j_reg;
        i_next          = i_reg;
        self_next       = self_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_root_next   = out_root_reg;
        mem_we          = 1'b0;
        mem_idx         = count_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_id_next   = s_id;
                    in_par_next  = s_par;
                    in_last_next = s_axis_tlast;
                    if (!s_axis_tuser)
                    begin
                        state_next = S_JUDGE;
                    end
                    else if (count_reg >= CW'(ptv_pkg::MAX_NODES))
                    begin
                        err_next   = ptv_pkg::ST_OVERFLOW;
                        state_next = s_axis_tlast ? S_JUDGE : S_IDLE;
                    end
                    else if (s_id == '0)
                    begin
                        err_next   = ptv_pkg::ST_ZERO;
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        if (s_par == '0)
                        begin
                            if (tally_reg != 2'd2)
                            begin
                                tally_next = tally_reg + 2'd1;
                            end
                            root_next = s_id;
                        end
                        if (err_reg == ptv_pkg::ST_OK && count_reg != '0)
                        begin
                            key_next   = s_id;
                            mode_next  = M_DUP;
                            j_next     = '0;
                            state_next = S_SRCH_RD;
                        end
                        else
                        begin
                            state_next = S_WRITE;
                        end
                    end
                end
            end

            S_WRITE:
            begin
                mem_we     = 1'b1;
                mem_idx    = count_reg;
                count_next = count_reg + CW'(1);
                state_next = in_last_reg ? S_JUDGE : S_IDLE;
            end

            S_SRCH_RD:
            begin
                mem_idx    = j_reg;
                state_next = S_SRCH_CMP;
            end

            S_SRCH_CMP:
            begin
                if (hit || (j_reg + CW'(1) == count_reg))
                begin
                    unique case (mode_reg)
                        M_DUP:
                        begin
                            if (hit)
                            begin
                                err_next = ptv_pkg::ST_DUP;
                            end
                            state_next = S_WRITE;
                        end
                        M_MISS:
                        begin
                            if (!hit)
                            begin
                                res_next   = ptv_pkg::ST_MISSING;
                                state_next = S_EMIT;
                            end
                            else if (i_reg + CW'(1) == count_reg)
                            begin
                                state_next = S_ROOTS;
                            end
                            else
                            begin
                                i_next     = i_reg + CW'(1);
                                state_next = S_MISS_RD;
                            end
                        end
                        M_WALK:
                        begin
                            if (hit)
                            begin
                                cur_next   = rd_par;
                                steps_next = steps_reg + CW'(1);
                                state_next = S_WALK_STEP;
                            end
                            else if (i_reg + CW'(1) == count_reg)
                            begin
                                res_next   = ptv_pkg::ST_OK;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                i_next     = i_reg + CW'(1);
                                state_next = S_WALK_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_SRCH_RD;
                end
            end

            S_JUDGE:
            begin
                if (err_reg == ptv_pkg::ST_OVERFLOW)
                begin
                    res_next   = ptv_pkg::ST_OVERFLOW;
                    state_next = S_EMIT;
                end
                else if (count_reg == '0)
                begin
                    res_next   = ptv_pkg::ST_EMPTY;
                    state_next = S_EMIT;
                end
                else if (err_reg != ptv_pkg::ST_OK)
                begin
                    res_next   = err_reg;
                    state_next = S_EMIT;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_MISS_RD;
                end
            end

            S_MISS_RD:
            begin
                mem_idx    = i_reg;
                state_next = S_MISS_CHK;
            end

            S_MISS_CHK:
            begin
                if (rd_par != '0)
                begin
                    key_next   = rd_par;
                    mode_next  = M_MISS;
                    j_next     = '0;
                    state_next = S_SRCH_RD;
                end
                else if (i_reg + CW'(1) == count_reg)
                begin
                    state_next = S_ROOTS;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_MISS_RD;
                end
            end

            S_ROOTS:
            begin
                if (tally_reg == 2'd0)
                begin
                    res_next   = ptv_pkg::ST_NOROOT;
                    state_next = S_EMIT;
                end
                else if (tally_reg != 2'd1)
                begin
                    res_next   = ptv_pkg::ST_MULTIROOT;
                    state_next = S_EMIT;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_WALK_RD;
                end
            end

            S_WALK_RD:
            begin
                mem_idx    = i_reg;
                state_next = S_WALK_INIT;
            end

            S_WALK_INIT:
            begin
                self_next  = rd_id;
                cur_next   = rd_par;
                steps_next = '0;
                state_next = S_WALK_STEP;
            end

            S_WALK_STEP:
            begin
                if (steps_reg >= step_limit)
                begin
                    res_next   = ptv_pkg::ST_DEEP;
                    state_next = S_EMIT;
                end
                else if (cur_reg == '0)
                begin
                    // chain reached a root: move to the next node
                    if (i_reg + CW'(1) == count_reg)
                    begin
                        res_next   = ptv_pkg::ST_OK;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = S_WALK_RD;
                    end
                end
                else if (cur_reg == self_reg)
                begin
                    res_next   = ptv_pkg::ST_CYCLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    key_next   = cur_reg;
                    mode_next  = M_WALK;
                    j_next     = '0;
                    state_next = S_SRCH_RD;
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg;
                    out_root_next   = (res_reg == ptv_pkg::ST_OK) ? root_reg : '0;
                    count_next      = '0;
                    tally_next      = '0;
                    root_next       = '0;
                    err_next        = ptv_pkg::ST_OK;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= M_DUP;
            count_reg      <= '0;
            tally_reg      <= '0;
            root_reg       <= '0;
            err_reg        <= ptv_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ptv_pkg::ST_OK;
            out_root_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            tally_reg      <= tally_next;
            root_reg       <= root_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_root_reg   <= out_root_next;
        end
    end

    // payload and walk registers, no reset needed
    always_ff @(posedge clk)
    begin
        in_id_reg   <= in_id_next;
        in_par_reg  <= in_par_next;
        in_last_reg <= in_last_next;
        key_reg     <= key_next;
        j_reg       <= j_next;
        i_reg       <= i_next;
        self_reg    <= self_next;
        cur_reg     <= cur_next;
        steps_reg   <= steps_next;
        res_reg     <= res_next;
    end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for parent_tree_validator_top: node lists in, one status word out.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // One input word as the block sees it
    typedef struct {
        logic        has;
        logic [31:0] id;
        logic [31:0] pid;
        logic        fin;
    } node_word_t;

    // One verdict: status plus root id
    typedef struct {
        logic [3:0]  status;
        logic [31:0] root;
    } verdict_t;

    // Directed row: a word and, where it is obvious, the verdict it must give
    typedef struct {
        node_word_t w;
        bit         typed;
        logic [3:0] st;
        logic [31:0] root;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // node_id[31:0], par_id[63:32]
    logic        s_axis_tuser;   // has_node
    logic        s_axis_tlast;   // last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // status[3:0], root_id[35:4], zero pad

    parent_tree_validator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Verdicts still owed by the block, oldest first
    verdict_t pending_verdicts[$];
    int       errors;
    int       verdicts_seen;
    int       lists_sent;
    int       words_sent;
    bit       no_gaps;          // stretches where both sides run flat out

    // Shadow copy of the node store and list flags
    logic [31:0] shadow_ids[$];
    logic [31:0] shadow_pids[$];
    int          shadow_roots;  // saturates at two
    logic [31:0] shadow_root;
    logic [3:0]  shadow_err;

    task automatic report(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic int find_id(input logic [31:0] id);
        for (int k = 0; k < shadow_ids.size(); k++)
            if (shadow_ids[k] == id)
                return k;
        return -1;
    endfunction

    // Judge the stored list once it ends
    function automatic logic [3:0] judge_list();
        int          n;
        int          steps;
        int          at;
        logic [31:0] cur;
        n = shadow_ids.size();
        if (shadow_err == ptv_pkg::ST_OVERFLOW)
            return ptv_pkg::ST_OVERFLOW;
        if (n == 0)
            return ptv_pkg::ST_EMPTY;
        if (shadow_err != ptv_pkg::ST_OK)
            return shadow_err;
        for (int i = 0; i < n; i++)
            if (shadow_pids[i] != 0 && find_id(shadow_pids[i]) < 0)
                return ptv_pkg::ST_MISSING;
        if (shadow_roots == 0)
            return ptv_pkg::ST_NOROOT;
        if (shadow_roots > 1)
            return ptv_pkg::ST_MULTIROOT;
        // walk every chain in list order; a loop missing the start is too deep
        for (int i = 0; i < n; i++)
        begin
            cur = shadow_pids[i];
            steps = 0;
            while (cur != 0 && steps < n + 1)
            begin
                if (cur == shadow_ids[i])
                    return ptv_pkg::ST_CYCLE;
                at = find_id(cur);
                if (at < 0)
                    break;
                cur = shadow_pids[at];
                steps++;
            end
            if (steps >= n + 1)
                return ptv_pkg::ST_DEEP;
        end
        return ptv_pkg::ST_OK;
    endfunction

    // Absorb one accepted word; tells whether it closes a list and with what
    task automatic absorb_word(input node_word_t w, output bit closes, output verdict_t v);
        closes = 1'b0;
        if (w.has)
        begin
            if (shadow_ids.size() >= ptv_pkg::MAX_NODES)
                shadow_err = ptv_pkg::ST_OVERFLOW;
            else
            begin
                if (w.id == 0)
                begin
                    if (shadow_err != ptv_pkg::ST_OVERFLOW)
                        shadow_err = ptv_pkg::ST_ZERO;
                end
                else
                begin
                    if (shadow_err == ptv_pkg::ST_OK && find_id(w.id) >= 0)
                        shadow_err = ptv_pkg::ST_DUP;
                    if (w.pid == 0)
                    begin
                        if (shadow_roots < 2)
                            shadow_roots++;
                        shadow_root = w.id;
                    end
                end
                shadow_ids.push_back(w.id);
                shadow_pids.push_back(w.pid);
            end
        end
        if (!w.has || w.fin)
        begin
            closes = 1'b1;
            v.status = judge_list();
            v.root = (v.status == ptv_pkg::ST_OK) ? shadow_root : 32'd0;
            shadow_ids.delete();
            shadow_pids.delete();
            shadow_roots = 0;
            shadow_root = '0;
            shadow_err = ptv_pkg::ST_OK;
        end
    endtask

    // Drive one word at the falling edge and hold it until it is taken
    task automatic send_word(input node_word_t w, input bit typed, input verdict_t typed_v);
        bit       closes;
        verdict_t v;
        int       gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = {w.pid, w.id};
        s_axis_tuser  = w.has;
        s_axis_tlast  = w.fin;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        absorb_word(w, closes, v);
        if (closes)
        begin
            pending_verdicts.push_back(typed ? typed_v : v);
            lists_sent++;
        end
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_plain(input node_word_t w);
        verdict_t none;
        none = '{status: ptv_pkg::ST_OK, root: '0};
        send_word(w, 1'b0, none);
    endtask

    // Small list: mostly a well-formed tree, sometimes broken on purpose
    task automatic small_list();
        int          n;
        int          a;
        int          b;
        int          tmp;
        int          flaw;
        bit          small_pool;
        bit          clash;
        logic [31:0] ids[8];
        logic [31:0] pids[8];
        int          order[8];
        node_word_t  w;
        n = $urandom_range(1, 8);
        small_pool = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n; k++)
        begin
            do
            begin
                ids[k] = small_pool ? $urandom_range(1, 12) : $urandom;
                clash = (ids[k] == 0);
                for (int j = 0; j < k; j++)
                    if (ids[j] == ids[k])
                        clash = 1'b1;
            end
            while (clash);
            pids[k] = (k == 0) ? 32'd0 : ids[$urandom_range(0, k - 1)];
            order[k] = k;
        end
        flaw = $urandom_range(0, 11);
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
        case (flaw)
            5: pids[a] = $urandom;                    // likely dangling parent
            6: if (n >= 3)
               begin                                  // two-node loop off the tree
                   a = $urandom_range(1, n - 1);
                   b = (a == n - 1) ? 1 : a + 1;
                   pids[a] = ids[b];
                   pids[b] = ids[a];
               end
            7: ids[a] = ids[b];                       // duplicate (or none if a==b)
            8: pids[a] = 32'd0;                       // extra root
            9: ids[a] = 32'd0;                        // zero id
            10: pids[0] = ids[b];                     // root removed, maybe self loop
            11: if (n >= 2) pids[a] = ids[a];         // self parent
            default: ;
        endcase
        for (int k = n - 1; k > 0; k--)
        begin
            a = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[a];
            order[a] = tmp;
        end
        tmp = ($urandom_range(0, 3) == 0);            // end by an empty word
        for (int k = 0; k < n; k++)
        begin
            w = '{has: 1'b1, id: ids[order[k]], pid: pids[order[k]],
                  fin: (k == n - 1) && !tmp};
            send_plain(w);
        end
        if (tmp)
        begin
            w = '{has: 1'b0, id: $urandom, pid: $urandom, fin: 1'($urandom_range(0, 1))};
            send_plain(w);
        end
    endtask

    // Large list of distinct roots; beyond MAX_NODES it must overflow
    task automatic big_list(input int n, input bit end_empty);
        node_word_t w;
        for (int k = 0; k < n; k++)
        begin
            w = '{has: 1'b1, id: 32'(k * 7 + 1), pid: 32'd0,
                  fin: (k == n - 1) && !end_empty};
            send_plain(w);
        end
        if (end_empty)
        begin
            w = '{has: 1'b0, id: '0, pid: '0, fin: 1'b0};
            send_plain(w);
        end
    endtask

    // Result side: random stalls, each verdict compared with the oldest one owed
    initial
    begin
        verdict_t want;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_axis_tready = 1'b0;
            if (!no_gaps)
                repeat ($urandom_range(0, 3)) @(negedge clk);
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            verdicts_seen++;
            if (pending_verdicts.size() == 0)
                report($sformatf("unexpected verdict %h", m_axis_tdata));
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[3:0] !== want.status)
                    report($sformatf("status %0d, want %0d", m_axis_tdata[3:0], want.status));
                if (m_axis_tdata[35:4] !== want.root)
                    report($sformatf("root %h, want %h", m_axis_tdata[35:4], want.root));
            end
        end
    end

    // Directed rows: corners of each status, then the random part
    row_t rows[$];

    task automatic add_row(input int h, input logic [31:0] id, input logic [31:0] pid,
                           input int f, input int typed, input int st,
                           input logic [31:0] root);
        row_t r;
        r.w = '{has: 1'(h), id: id, pid: pid, fin: 1'(f)};
        r.typed = 1'(typed);
        r.st = 4'(st);
        r.root = root;
        rows.push_back(r);
    endtask

    initial
    begin
        verdict_t tv;
        errors = 0;
        verdicts_seen = 0;
        lists_sent = 0;
        words_sent = 0;
        no_gaps = 1'b0;
        shadow_roots = 0;
        shadow_root = '0;
        shadow_err = ptv_pkg::ST_OK;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        add_row(0, 32'h0, 32'h0, 0, 1, ptv_pkg::ST_EMPTY, 0);        // empty list
        add_row(0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1, ptv_pkg::ST_EMPTY, 0); // last ignored
        add_row(1, 32'hFFFFFFFF, 32'h0, 1, 1, ptv_pkg::ST_OK, 32'hFFFFFFFF); // single root
        add_row(1, 32'h1, 32'h0, 0, 0, 0, 0);
        add_row(1, 32'h0, 32'h1, 1, 1, ptv_pkg::ST_ZERO, 0);         // zero id
        add_row(1, 32'h5, 32'h0, 0, 0, 0, 0);
        add_row(1, 32'h5, 32'h5, 1, 1, ptv_pkg::ST_DUP, 0);          // duplicate
        add_row(1, 32'h7, 32'h0, 0, 0, 0, 0);
        add_row(1, 32'h8, 32'h9, 1, 1, ptv_pkg::ST_MISSING, 0);      // dangling parent
        add_row(1, 32'h3, 32'h3, 1, 1, ptv_pkg::ST_NOROOT, 0);       // self loop, no root
        add_row(1, 32'h1, 32'h0, 0, 0, 0, 0);
        add_row(1, 32'h2, 32'h0, 1, 1, ptv_pkg::ST_MULTIROOT, 0);    // two roots
        add_row(1, 32'h1, 32'h0, 0, 0, 0, 0);
        add_row(1, 32'h2, 32'h3, 0, 0, 0, 0);
        add_row(1, 32'h3, 32'h2, 1, 1, ptv_pkg::ST_CYCLE, 0);        // loop through start
        add_row(1, 32'h1, 32'h0, 0, 0, 0, 0);
        add_row(1, 32'h2, 32'h3, 0, 0, 0, 0);
        add_row(1, 32'h3, 32'h4, 0, 0, 0, 0);
        add_row(1, 32'h4, 32'h3, 1, 1, ptv_pkg::ST_DEEP, 0);         // runs into a loop
        add_row(1, 32'hAAAAAAAA, 32'h0, 0, 0, 0, 0);
        add_row(1, 32'h55555555, 32'hAAAAAAAA, 1, 0, 0, 0);          // bit-pattern tree
        add_row(1, 32'h55555555, 32'h0, 0, 0, 0, 0);
        add_row(1, 32'hAAAAAAAA, 32'h55555555, 0, 0, 0, 0);
        add_row(0, 32'h12345678, 32'h9ABCDEF0, 0, 1, ptv_pkg::ST_OK, 32'h55555555);

        foreach (rows[i])
        begin
            tv = '{status: rows[i].st, root: rows[i].root};
            send_word(rows[i].w, rows[i].typed, tv);
        end

        // Full store, then two nodes past it
        big_list(ptv_pkg::MAX_NODES, 1'b1);
        big_list(ptv_pkg::MAX_NODES + 2, 1'b0);

        while (words_sent < 650)
        begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
                send_plain('{has: 1'b0, id: $urandom, pid: $urandom,
                             fin: 1'($urandom_range(0, 1))});
            else
                small_list();
        end
        no_gaps = 1'b0;
        s_axis_tvalid = 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Checked %0d verdicts over %0d lists: every status, full store and overflow.",
                 verdicts_seen, lists_sent);
        if (errors == 0)
            $display("PASS parent_tree_validator_top");
        else
            $display("FAIL parent_tree_validator_top");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40ms;
        $display("Timed out with %0d verdicts outstanding", pending_verdicts.size());
        $display("FAIL parent_tree_validator_top");
        $finish;
    end

endmodule
